### design/bpa_pkg.sv
// Package: shared types, sizes and request codes of the bitmap page allocator.
`default_nettype none
package bpa_pkg;

	// Default geometry of the page bitmap
	localparam int NUM_WORDS_DEF = 1024;
	localparam int WORD_BITS_DEF = 32;

	// Field widths
	localparam int PAGE_W  = 15;
	localparam int COUNT_W = 16;
	localparam int KIND_W  = 2;

	// Summary words: one bit per bitmap word, grouped in words of SUM_BITS bits
	localparam int SUM_BITS = 32;
	localparam int SUM_IW   = 5;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MARK  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PAGE_W-1:0] page_index;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  alloc_page;
		logic               alloc_ok;
		logic [COUNT_W-1:0] free_count;
		logic [COUNT_W-1:0] used_count;
	} rsp_t;

endpackage
`default_nettype wire

### design/bpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### design/bpa_lsb_find.sv
// Lowest-set-bit finder: index of the least significant one in a vector.
`default_nettype none
module bpa_lsb_find #(
	parameter int WIDTH = 32,
	parameter int IW    = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
	input  wire logic [WIDTH-1:0] vec,
	output logic      [IW-1:0]    idx,
	output logic                  found
);

	always_comb begin
		idx = '0;
		// scan from the top so the lowest set bit wins
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IW'(i);
			end
		end
	end

	assign found = |vec;

endmodule
`default_nettype wire

### design/bitmap_page_allocator.sv
// Top level: first-fit bitmap page allocator with a two-level free summary.
//
//   channel | direction | valid     | stall     | payload
//   --------+-----------+-----------+-----------+----------------------------------
//   req     | in        | req_valid | req_stall | req (kind, page_index)
//   rsp     | out       | rsp_valid | rsp_stall | rsp (alloc_page, alloc_ok, counts)
//
// One request is worked at a time; req_stall stays high from acceptance until idle again.
// Allocate (top vector -> summary word -> bitmap word) steps through ST_ALC0, ST_ALC1 and
// ST_ALC2, free/mark-used through ST_DIV1, ST_DIV2 and ST_RMW, then ST_FIN loads the result
// register; a query goes straight to ST_FIN, an allocate that finds nothing free leaves early.
// Reset clears the sequencer, top vector, counter and rsp_valid; memory words are trusted only
// where the level above marks them nonzero. rsp_stall holds the sequencer in its last state.
`default_nettype none
module bitmap_page_allocator #(
	parameter int NUM_WORDS = bpa_pkg::NUM_WORDS_DEF,
	parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire bpa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output bpa_pkg::rsp_t      rsp
);

	import bpa_pkg::*;

	// Geometry
	localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int SUM_DEPTH = (NUM_WORDS + SUM_BITS - 1) / SUM_BITS;
	localparam int SAW       = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

	// page / WORD_BITS as a multiply by a rounded-down reciprocal,
	// then at most one correction step
	localparam int               DIV_K = PAGE_W + BW;
	localparam logic [16:0]      DIV_M = 17'((2 ** DIV_K) / WORD_BITS);
	localparam int               PROD_W = PAGE_W + 17;
	localparam int               MULW_W = PAGE_W + BW + 1;

	localparam logic [COUNT_W-1:0] TOTAL_LO =
		COUNT_W'((NUM_WORDS * WORD_BITS) % (2 ** COUNT_W));
	localparam logic [PAGE_W:0]    NUM_WORDS_V = (PAGE_W + 1)'(NUM_WORDS);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ALC0 = 3'd1;
	localparam logic [2:0] ST_ALC1 = 3'd2;
	localparam logic [2:0] ST_ALC2 = 3'd3;
	localparam logic [2:0] ST_DIV1 = 3'd4;
	localparam logic [2:0] ST_DIV2 = 3'd5;
	localparam logic [2:0] ST_RMW  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]           state_q;
	logic [KIND_W-1:0]    kind_q;
	logic [PAGE_W-1:0]    page_q;
	logic [PAGE_W-1:0]    q0_q;
	logic [PAGE_W-1:0]    w_q;      // word index
	logic [BW-1:0]        b_q;      // bit index inside the word
	logic [SUM_BITS-1:0]  sd_q;     // summary word held for allocate
	logic                 ok_q;
	logic [SUM_DEPTH-1:0] top_q;    // one bit per nonzero summary word
	logic [COUNT_W-1:0]   free_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// Memory ports
	logic                 bm_we;
	logic [WW-1:0]        bm_waddr;
	logic [WORD_BITS-1:0] bm_wdata;
	logic [WW-1:0]        bm_raddr;
	logic [WORD_BITS-1:0] bm_rdata;
	logic                 sum_we;
	logic [SAW-1:0]       sum_waddr;
	logic [SUM_BITS-1:0]  sum_wdata;
	logic [SAW-1:0]       sum_raddr;
	logic [SUM_BITS-1:0]  sum_rdata;

	// Finders
	logic [SAW-1:0]       top_idx;
	logic                 top_found;
	logic [SUM_IW-1:0]    sum_idx;
	logic                 sum_found;
	logic [BW-1:0]        word_idx;
	logic                 word_found;

	// Working values
	logic [PROD_W-1:0]    div_prod;
	logic [MULW_W-1:0]    q0_times;
	logic [BW:0]          rem0;
	logic [PAGE_W-1:0]    w_div;
	logic [BW-1:0]        b_div;
	logic                 w_in_range;
	logic [SAW-1:0]       s_cur;
	logic [SUM_IW-1:0]    j_cur;
	logic [SUM_BITS-1:0]  sd_eff;
	logic [WORD_BITS-1:0] wd_eff;
	logic [WORD_BITS-1:0] bit_m;
	logic [SUM_BITS-1:0]  sum_m;
	logic                 was_free;
	logic [WORD_BITS-1:0] word_new;
	logic [SUM_BITS-1:0]  sum_new;
	logic [MULW_W-1:0]    page_full;
	logic                 fin_go;

	bpa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	bpa_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (SUM_DEPTH)
	) u_summary (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	bpa_lsb_find #(.WIDTH(SUM_DEPTH), .IW(SAW)) u_top_find (
		.vec   (top_q),
		.idx   (top_idx),
		.found (top_found)
	);

	bpa_lsb_find #(.WIDTH(SUM_BITS), .IW(SUM_IW)) u_sum_find (
		.vec   (sum_rdata),
		.idx   (sum_idx),
		.found (sum_found)
	);

	bpa_lsb_find #(.WIDTH(WORD_BITS), .IW(BW)) u_word_find (
		.vec   (wd_eff),
		.idx   (word_idx),
		.found (word_found)
	);

	// Divide stage arithmetic
	assign div_prod = PROD_W'(page_q) * PROD_W'(DIV_M);
	assign q0_times = MULW_W'(q0_q) * MULW_W'(WORD_BITS);
	assign rem0     = (BW + 1)'(MULW_W'(page_q) - q0_times);

	always_comb begin
		if (rem0 >= (BW + 1)'(WORD_BITS)) begin
			w_div = q0_q + PAGE_W'(1);
			b_div = BW'(rem0 - (BW + 1)'(WORD_BITS));
		end else begin
			w_div = q0_q;
			b_div = BW'(rem0);
		end
	end

	assign w_in_range = {1'b0, w_div} < NUM_WORDS_V;

	// Summary coordinates of the word in hand
	assign s_cur = w_q[SUM_IW +: SAW];
	assign j_cur = w_q[SUM_IW-1:0];
	assign sum_m = SUM_BITS'(1) << j_cur;
	assign bit_m = WORD_BITS'(1) << b_q;

	// Trust memory data only where the level above marks it nonzero
	always_comb begin
		if (state_q == ST_ALC2) begin
			sd_eff = sd_q;
			wd_eff = bm_rdata;
		end else begin
			sd_eff = top_q[s_cur] ? sum_rdata : '0;
			wd_eff = sd_eff[j_cur] ? bm_rdata : '0;
		end
	end

	assign was_free = |(wd_eff & bit_m);

	// Read addresses
	always_comb begin
		sum_raddr = top_idx;
		bm_raddr  = WW'({s_cur, sum_idx});
		if (state_q == ST_DIV2) begin
			sum_raddr = w_div[SUM_IW +: SAW];
			bm_raddr  = w_div[WW-1:0];
		end
	end

	// Read-modify-write
	always_comb begin
		bm_we     = 1'b0;
		sum_we    = 1'b0;
		word_new  = wd_eff;
		sum_new   = sd_eff;
		bm_waddr  = w_q[WW-1:0];
		sum_waddr = s_cur;
		unique case (state_q)
			ST_ALC2: begin
				word_new = wd_eff & ~(WORD_BITS'(1) << word_idx);
				sum_new  = (word_new == '0) ? (sd_eff & ~sum_m) : sd_eff;
				bm_we    = word_found;
				sum_we   = word_found;
			end
			ST_RMW: begin
				if (kind_q == KIND_FREE && !was_free) begin
					word_new = wd_eff | bit_m;
					sum_new  = sd_eff | sum_m;
					bm_we    = 1'b1;
					sum_we   = 1'b1;
				end else if (kind_q == KIND_MARK && was_free) begin
					word_new = wd_eff & ~bit_m;
					sum_new  = (word_new == '0) ? (sd_eff & ~sum_m) : sd_eff;
					bm_we    = 1'b1;
					sum_we   = 1'b1;
				end
			end
			default: begin
			end
		endcase
		bm_wdata  = word_new;
		sum_wdata = sum_new;
	end

	assign page_full = MULW_W'(w_q) * MULW_W'(WORD_BITS) + MULW_W'(b_q);
	assign fin_go    = !rsp_valid_q || !rsp_stall;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q   <= '0;
			free_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						unique case (req.kind)
							KIND_ALLOC: state_q <= ST_ALC0;
							KIND_FREE:  state_q <= ST_DIV1;
							KIND_MARK:  state_q <= ST_DIV1;
							KIND_QUERY: state_q <= ST_FIN;
						endcase
					end
				end
				ST_ALC0: begin
					// nothing free: fail straight away
					state_q <= top_found ? ST_ALC1 : ST_FIN;
				end
				ST_ALC1: begin
					state_q <= sum_found ? ST_ALC2 : ST_FIN;
				end
				ST_ALC2: begin
					if (word_found) begin
						top_q[s_cur] <= |sum_new;
						free_q       <= free_q - COUNT_W'(1);
					end
					state_q <= ST_FIN;
				end
				ST_DIV1: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					// drop requests beyond the bitmap
					state_q <= w_in_range ? ST_RMW : ST_FIN;
				end
				ST_RMW: begin
					if (sum_we) begin
						top_q[s_cur] <= |sum_new;
						free_q <= (kind_q == KIND_FREE) ? free_q + COUNT_W'(1)
						                                : free_q - COUNT_W'(1);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q <= req.kind;
				page_q <= req.page_index;
				ok_q   <= 1'b0;
			end
			ST_ALC0: begin
				w_q <= PAGE_W'({top_idx, {SUM_IW{1'b0}}});
			end
			ST_ALC1: begin
				w_q  <= PAGE_W'({s_cur, sum_idx});
				sd_q <= sum_rdata;
			end
			ST_ALC2: begin
				b_q  <= word_idx;
				ok_q <= word_found;
			end
			ST_DIV1: begin
				q0_q <= PAGE_W'(div_prod >> DIV_K);
			end
			ST_DIV2: begin
				w_q <= w_div;
				b_q <= b_div;
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && fin_go) begin
			rsp_q.alloc_page <= ok_q ? page_full[PAGE_W-1:0] : '0;
			rsp_q.alloc_ok   <= ok_q;
			rsp_q.free_count <= free_q;
			rsp_q.used_count <= TOTAL_LO - free_q;
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

### verif/bitmap_page_allocator_checker.sv
// Checker: tracks the page bitmap, predicts each result and compares it on the response channel.
`timescale 1ns / 1ps
module bitmap_page_allocator_checker #(
	parameter int NUM_WORDS = bpa_pkg::NUM_WORDS_DEF,
	parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  bpa_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  bpa_pkg::rsp_t rsp,
	output int            pending_results,
	output int            mismatches
);
	import bpa_pkg::*;

	localparam int TOTAL_PAGES = NUM_WORDS * WORD_BITS;

	logic [WORD_BITS-1:0] free_map [NUM_WORDS];
	int                   free_total;
	rsp_t                 page_result_q [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR: %s", $time, msg);
		mismatches++;
	endtask

	// Apply one request to the tracked bitmap and return the result it yields.
	function automatic rsp_t update_page_map(input req_t r);
		rsp_t res;
		int   w;
		int   b;
		int   used;
		logic found;
		res   = '0;
		found = 1'b0;
		case (r.kind)
			KIND_ALLOC: begin
				// First fit: lowest word with any free bit, then lowest bit in it.
				for (w = 0; w < NUM_WORDS && !found; w++) begin
					if (free_map[w] != '0) begin
						for (b = 0; b < WORD_BITS && !found; b++) begin
							if (free_map[w][b]) begin
								found          = 1'b1;
								free_map[w][b] = 1'b0;
								free_total--;
								res.alloc_page = PAGE_W'(w * WORD_BITS + b);
								res.alloc_ok   = 1'b1;
							end
						end
					end
				end
			end
			KIND_FREE, KIND_MARK: begin
				w = int'(r.page_index) / WORD_BITS;
				b = int'(r.page_index) % WORD_BITS;
				if (w < NUM_WORDS) begin
					// Move the counter only when the bit really flips.
					if (r.kind == KIND_FREE && !free_map[w][b]) begin
						free_map[w][b] = 1'b1;
						free_total++;
					end else if (r.kind == KIND_MARK && free_map[w][b]) begin
						free_map[w][b] = 1'b0;
						free_total--;
					end
				end
			end
			default: ;
		endcase
		used           = TOTAL_PAGES - free_total;
		res.free_count = free_total[COUNT_W-1:0];
		res.used_count = used[COUNT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int w = 0; w < NUM_WORDS; w++)
				free_map[w] = '0;
			free_total = 0;
			mismatches = 0;
			page_result_q.delete();
			pending_results <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (page_result_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: %h", rsp));
				end else begin
					want = page_result_q.pop_front();
					if (rsp.alloc_page !== want.alloc_page)
						report_mismatch($sformatf("alloc_page got %0d want %0d",
							rsp.alloc_page, want.alloc_page));
					if (rsp.alloc_ok !== want.alloc_ok)
						report_mismatch($sformatf("alloc_ok got %b want %b",
							rsp.alloc_ok, want.alloc_ok));
					if (rsp.free_count !== want.free_count)
						report_mismatch($sformatf("free_count got %0d want %0d",
							rsp.free_count, want.free_count));
					if (rsp.used_count !== want.used_count)
						report_mismatch($sformatf("used_count got %0d want %0d",
							rsp.used_count, want.used_count));
				end
			end
			if (req_valid && !req_stall)
				page_result_q.push_back(update_page_map(req));
			pending_results <= page_result_q.size();
		end
	end

endmodule

### verif/bitmap_page_allocator_tb.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and the verdict.
`timescale 1ns / 1ps
module bitmap_page_allocator_tb;
	import bpa_pkg::*;

	// Random requests to issue after the directed opening.
	localparam int RANDOM_ITEMS = 2000;
	// Length of the deliberate response hold-off, in cycles.
	localparam int HOLD_CYCLES  = 200;
	// Highest page number a 15-bit index can name.
	localparam int LAST_PAGE    = (1 << PAGE_W) - 1;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int pending_results;
	int mismatches;

	// Hold-off handshake between the stimulus and the receiver process:
	// bump hold_requests to ask for one long stall, the receiver tracks
	// how many it has already served.
	int hold_requests = 0;
	int hold_served   = 0;
	int rx_stall_left = 0;
	int rx_run_left   = 0;

	always #5 clk = ~clk;

	bitmap_page_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	bitmap_page_allocator_checker page_map_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp),
		.pending_results (pending_results),
		.mismatches      (mismatches)
	);

	// Receiver: alternate runs of readiness with stalls, mostly short ones,
	// now and then a long one, and sometimes a long stretch with no stall
	// at all. A pending hold-off request overrides the pattern and keeps
	// the response side stalled for the whole hold-off so the block backs up.
	always @(posedge clk) begin
		int r;
		if (hold_served != hold_requests) begin
			hold_served   = hold_requests;
			rx_stall_left = HOLD_CYCLES;
			rx_run_left   = 0;
		end else if (rx_stall_left == 0 && rx_run_left == 0) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				rx_run_left = $urandom_range(40, 150);
			end else begin
				rx_run_left = $urandom_range(0, 6);
				r = $urandom_range(0, 99);
				if (r < 75)
					rx_stall_left = $urandom_range(1, 3);
				else if (r < 96)
					rx_stall_left = $urandom_range(4, 10);
				else
					rx_stall_left = $urandom_range(20, 60);
			end
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			if (rx_run_left > 0)
				rx_run_left--;
			rsp_stall <= 1'b0;
		end
	end

	// Idle time after a request: gap_mode 0 never idles, otherwise mostly
	// back to back, some short gaps and a few long ones.
	function automatic int pick_gap(input int gap_mode);
		int r;
		if (gap_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one transaction and hold it until the block takes it, then
	// drop valid for the requested gap. With no gap, valid stays high so
	// the caller can put the next transaction right behind it.
	task automatic send_request(input logic [KIND_W-1:0] kind,
		input logic [PAGE_W-1:0] page, input int gap);
		req_valid <= 1'b1;
		req       <= '{kind: kind, page_index: page};
		do @(posedge clk); while (req_stall);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Pause the sender until every transaction has come back.
	task automatic wait_all_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	// Stimulus: directed opening, then random phases over page windows.
	initial begin
		int          issued;
		int          phase;
		int          style;
		int          gap_mode;
		int          span;
		int          base;
		int          count;
		int          r;
		logic [KIND_W-1:0] kind;
		logic [PAGE_W-1:0] page;

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: everything starts used, so allocate must fail first.
		send_request(KIND_ALLOC, '0, pick_gap(1));
		send_request(KIND_QUERY, '0, pick_gap(1));
		// Mark an already used page: no counter movement.
		send_request(KIND_MARK,  '0, pick_gap(1));
		// Free the very last page, then free it again.
		send_request(KIND_FREE,  PAGE_W'(LAST_PAGE), pick_gap(1));
		send_request(KIND_FREE,  PAGE_W'(LAST_PAGE), pick_gap(1));
		send_request(KIND_FREE,  '0, pick_gap(1));
		send_request(KIND_FREE,  15'h5555, pick_gap(1));
		send_request(KIND_FREE,  15'h2AAA, pick_gap(1));
		// Word boundary: last bit of word 0 and first bit of word 1.
		send_request(KIND_FREE,  15'd31, pick_gap(1));
		send_request(KIND_FREE,  15'd32, pick_gap(1));
		send_request(KIND_QUERY, 15'h7FFF, pick_gap(1));
		// Mark a free page used, then mark it again.
		send_request(KIND_MARK,  15'h5555, pick_gap(1));
		send_request(KIND_MARK,  15'h5555, pick_gap(1));
		// Allocate in first-fit order until the bitmap runs dry.
		send_request(KIND_ALLOC, 15'h1234, pick_gap(1));
		send_request(KIND_ALLOC, '0, pick_gap(1));
		send_request(KIND_ALLOC, '0, pick_gap(1));
		send_request(KIND_ALLOC, 15'h7FFF, pick_gap(1));
		send_request(KIND_ALLOC, '0, pick_gap(1));
		send_request(KIND_ALLOC, '0, pick_gap(1));
		// Free and reclaim the top page once more, then query.
		send_request(KIND_FREE,  PAGE_W'(LAST_PAGE), pick_gap(1));
		send_request(KIND_MARK,  PAGE_W'(LAST_PAGE), pick_gap(1));
		send_request(KIND_QUERY, '0, pick_gap(1));
		wait_all_results();

		// Random phases. Each phase picks a style (fill the bitmap, drain
		// it with allocations, or a mix), a page window so frees and marks
		// hit pages that allocate will actually reach, and an idle mode.
		issued = 0;
		phase  = 0;
		while (issued < RANDOM_ITEMS) begin
			style    = $urandom_range(0, 2);
			gap_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
			span     = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600)
				: $urandom_range(4, 64);
			case ($urandom_range(0, 2))
				0:       base = 0;
				1:       base = $urandom_range(0, LAST_PAGE + 1 - span);
				default: base = LAST_PAGE + 1 - span;
			endcase
			count = $urandom_range(60, 140);

			// Early on, ask the receiver for its long hold-off and keep
			// offering back to back so the block fills and stalls us.
			if (phase == 2) begin
				hold_requests <= hold_requests + 1;
				gap_mode = 0;
			end

			for (int i = 0; i < count; i++) begin
				r = $urandom_range(0, 99);
				case (style)
					0: kind = (r < 70) ? KIND_FREE : (r < 80) ? KIND_ALLOC
						: (r < 90) ? KIND_MARK : KIND_QUERY;
					1: kind = (r < 80) ? KIND_ALLOC : (r < 88) ? KIND_FREE
						: (r < 95) ? KIND_MARK : KIND_QUERY;
					default: kind = (r < 35) ? KIND_FREE : (r < 65) ? KIND_ALLOC
						: (r < 85) ? KIND_MARK : KIND_QUERY;
				endcase
				// Mostly inside the window, now and then anywhere.
				if ($urandom_range(0, 19) == 0)
					page = PAGE_W'($urandom_range(0, LAST_PAGE));
				else
					page = PAGE_W'(base + $urandom_range(0, span - 1));
				send_request(kind, page, pick_gap(gap_mode));
				issued++;
			end

			if (phase % 4 == 3)
				wait_all_results();
			phase++;
		end

		// Drain, let the pipeline settle, then give the verdict.
		wait_all_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
